@@ rtl/tmtw_pkg.sv @@
// Shared types and constants for the text-mode terminal writer.
// Holds the screen geometry, command and character codes, and the cursor plan struct.
// Has no dependencies; every other file refers to it by scoped names.
package tmtw_pkg;

    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int CELL_COUNT    = ROWS * COLUMNS;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    localparam int ADDR_W  = $clog2(CELL_COUNT);
    localparam int SWP_W   = $clog2(CELL_COUNT + 1);
    localparam int COL_W   = $clog2(COLUMNS);
    localparam int ROW_W   = $clog2(ROWS);
    localparam int CELL_W  = 16;
    localparam int CHAR_W  = 8;
    localparam int COLOR_W = 8;
    localparam int CMD_W   = 2;
    localparam int IO_ADDR_W = 11;

    localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0]  CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0]  CH_BLANK     = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h0A;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CHAR_W-1:0] wr_char;
        logic              scroll;
    } cur_plan_t;

endpackage

@@ rtl/text_mode_terminal_writer_core.sv @@
// Top level of the text-mode terminal writer: command sequencer, sweep engine and result beat.
// Depends on tmtw_pkg, tmtw_screen_ram and tmtw_cursor.
//
// The block keeps an 80 by 25 screen of 16-bit cells (attribute byte high, character low) in
// one memory with one write port and one read port, and takes one command beat at a time. A put
// character, read cell or unused command goes from acceptance to the finish step, which loads
// the result beat into the output register, and the next command can be accepted once the
// block is back in idle. A put that runs past the last row first copies rows 1 to 24 up
// through the memory and then blanks the bottom row before the finish step. A clear blanks
// every cell before the finish step. After reset a clearing pass fills the screen with blanks
// in the reset color; commands stall during it, while writes to the color register are taken at
// any time. Every sweep goes through the single memory write port. A finished result waits in
// an output register, and the next command is accepted only in a cycle where that register is
// empty or its beat leaves.
module text_mode_terminal_writer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tmtw_pkg::COLOR_W-1:0]   cfg_wdata,
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  logic [tmtw_pkg::CMD_W-1:0]     command,
    input  logic [tmtw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tmtw_pkg::IO_ADDR_W-1:0] cell_address,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [tmtw_pkg::CELL_W-1:0]    cell_data,
    output logic [tmtw_pkg::IO_ADDR_W-1:0] cursor_position,
    output logic                           scrolled
);

    localparam int ADDR_W = tmtw_pkg::ADDR_W;
    localparam int SWP_W  = tmtw_pkg::SWP_W;

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SCROLL = 5'b00100,
        ST_BLANK  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [SWP_W-1:0]                sweep_reg, sweep_next;
    logic [tmtw_pkg::COLOR_W-1:0]    text_color_reg, text_color_next;
    logic                            hit_reg, hit_next;
    logic                            scroll_pend_reg, scroll_pend_next;
    logic                            rsp_valid_reg, rsp_valid_next;
    logic [tmtw_pkg::CELL_W-1:0]     cell_data_reg, cell_data_next;
    logic [tmtw_pkg::IO_ADDR_W-1:0]  cursor_position_reg, cursor_position_next;
    logic                            scrolled_reg, scrolled_next;

    logic                            accept;
    logic                            in_range;
    logic                            cur_step;
    logic                            cur_home;
    tmtw_pkg::cur_plan_t             plan;
    logic [ADDR_W-1:0]               cursor_addr;

    logic                            ram_we;
    logic [ADDR_W-1:0]               ram_waddr;
    logic [tmtw_pkg::CELL_W-1:0]     ram_wdata;
    logic                            ram_re;
    logic [ADDR_W-1:0]               ram_raddr;
    logic [tmtw_pkg::CELL_W-1:0]     ram_rdata;

    assign cmd_stall = !((state_reg == ST_IDLE) && (!rsp_valid_reg || !rsp_stall));
    assign accept    = cmd_valid && !cmd_stall;
    assign in_range  = (32'(cell_address) < 32'(tmtw_pkg::CELL_COUNT));
    assign cur_step  = accept && (command == tmtw_pkg::CMD_PUT);
    assign cur_home  = accept && (command == tmtw_pkg::CMD_CLEAR);

    tmtw_cursor u_cursor (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (cur_step),
        .home        (cur_home),
        .char_code   (char_code),
        .plan        (plan),
        .cursor_addr (cursor_addr)
    );

    tmtw_screen_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next           = state_reg;
        sweep_next           = sweep_reg;
        text_color_next      = cfg_we ? cfg_wdata : text_color_reg;
        hit_next             = hit_reg;
        scroll_pend_next     = scroll_pend_reg;
        rsp_valid_next       = rsp_valid_reg && rsp_stall;
        cell_data_next       = cell_data_reg;
        cursor_position_next = cursor_position_reg;
        scrolled_next        = scrolled_reg;
        ram_we               = 1'b0;
        ram_waddr            = '0;
        ram_wdata            = '0;
        ram_re               = 1'b0;
        ram_raddr            = '0;

        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg[ADDR_W-1:0];
                ram_wdata = {tmtw_pkg::RESET_COLOR, tmtw_pkg::CH_BLANK};
                if (sweep_reg == SWP_W'(tmtw_pkg::CELL_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + SWP_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    hit_next         = 1'b0;
                    scroll_pend_next = 1'b0;
                    state_next       = ST_FINISH;
                    unique case (command)
                        tmtw_pkg::CMD_PUT:
                        begin
                            ram_we    = plan.wr_en;
                            ram_waddr = plan.wr_addr;
                            ram_wdata = {text_color_reg, plan.wr_char};
                            if (plan.scroll)
                            begin
                                scroll_pend_next = 1'b1;
                                sweep_next       = SWP_W'(tmtw_pkg::COLUMNS);
                                state_next       = ST_SCROLL;
                            end
                        end
                        tmtw_pkg::CMD_READ:
                        begin
                            hit_next  = in_range;
                            ram_re    = in_range;
                            ram_raddr = ADDR_W'(cell_address);
                        end
                        tmtw_pkg::CMD_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = ST_BLANK;
                        end
                        default:
                        begin
                            state_next = ST_FINISH;
                        end
                    endcase
                end
            end
            ST_SCROLL:
            begin
                ram_re    = (32'(sweep_reg) < 32'(tmtw_pkg::CELL_COUNT));
                ram_raddr = sweep_reg[ADDR_W-1:0];
                ram_we    = (sweep_reg != SWP_W'(tmtw_pkg::COLUMNS));
                ram_waddr = ADDR_W'(sweep_reg - SWP_W'(tmtw_pkg::COLUMNS + 1));
                ram_wdata = ram_rdata;
                if (sweep_reg == SWP_W'(tmtw_pkg::CELL_COUNT))
                begin
                    sweep_next = SWP_W'(tmtw_pkg::LAST_ROW_BASE);
                    state_next = ST_BLANK;
                end
                else
                begin
                    sweep_next = sweep_reg + SWP_W'(1);
                end
            end
            ST_BLANK:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg[ADDR_W-1:0];
                ram_wdata = {text_color_reg, tmtw_pkg::CH_BLANK};
                if (sweep_reg == SWP_W'(tmtw_pkg::CELL_COUNT - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    sweep_next = sweep_reg + SWP_W'(1);
                end
            end
            ST_FINISH:
            begin
                rsp_valid_next       = 1'b1;
                cell_data_next       = hit_reg ? ram_rdata : '0;
                cursor_position_next = tmtw_pkg::IO_ADDR_W'(cursor_addr);
                scrolled_next        = scroll_pend_reg;
                state_next           = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            sweep_reg       <= '0;
            text_color_reg  <= tmtw_pkg::RESET_COLOR;
            hit_reg         <= 1'b0;
            scroll_pend_reg <= 1'b0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            sweep_reg       <= sweep_next;
            text_color_reg  <= text_color_next;
            hit_reg         <= hit_next;
            scroll_pend_reg <= scroll_pend_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_data_reg       <= cell_data_next;
        cursor_position_reg <= cursor_position_next;
        scrolled_reg        <= scrolled_next;
    end

    assign rsp_valid       = rsp_valid_reg;
    assign cell_data       = cell_data_reg;
    assign cursor_position = cursor_position_reg;
    assign scrolled        = scrolled_reg;

    // A new result beat is only ever produced by the finish step.
    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result beat appeared without a finish step");

    // The row copy sweep stays between the second row and one past the last cell.
    a_scroll_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCROLL |->
            (32'(sweep_reg) >= 32'(tmtw_pkg::COLUMNS)) &&
            (32'(sweep_reg) <= 32'(tmtw_pkg::CELL_COUNT)))
        else $error("scroll sweep out of range");

    // A scrolling item always leaves the cursor at the start of the last row.
    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && scrolled_reg |->
            32'(cursor_position_reg) == 32'(tmtw_pkg::LAST_ROW_BASE))
        else $error("scrolled result with cursor off the last row");

    // The cursor never points past the screen.
    a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
        32'(cursor_addr) < 32'(tmtw_pkg::CELL_COUNT))
        else $error("cursor outside the screen");

endmodule

@@ rtl/tmtw_screen_ram.sv @@
// Screen cell memory: one write port and one read port with registered read data.
// Depends on tmtw_pkg for the cell count and widths.
module tmtw_screen_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [tmtw_pkg::ADDR_W-1:0] waddr,
    input  logic [tmtw_pkg::CELL_W-1:0] wdata,
    input  logic                       re,
    input  logic [tmtw_pkg::ADDR_W-1:0] raddr,
    output logic [tmtw_pkg::CELL_W-1:0] rdata
);

    logic [tmtw_pkg::CELL_W-1:0] mem [tmtw_pkg::CELL_COUNT];
    logic [tmtw_pkg::CELL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tmtw_cursor.sv @@
// Cursor registers and the per-character cursor update and cell write plan.
// Depends on tmtw_pkg for geometry, character codes and the plan struct.
module tmtw_cursor (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic                        home,
    input  logic [tmtw_pkg::CHAR_W-1:0] char_code,
    output tmtw_pkg::cur_plan_t         plan,
    output logic [tmtw_pkg::ADDR_W-1:0] cursor_addr
);

    localparam int ADDR_W = tmtw_pkg::ADDR_W;
    localparam int COL_W  = tmtw_pkg::COL_W;
    localparam int ROW_W  = tmtw_pkg::ROW_W;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    logic [COL_W:0]    tab_sum;
    logic [COL_W:0]    tab_col;
    logic              last_row;
    logic              advance;
    logic [ADDR_W-1:0] nl_addr;

    always_comb
    begin
        plan      = '0;
        row_next  = row_reg;
        col_next  = col_reg;
        addr_next = addr_reg;
        advance   = 1'b0;
        tab_sum   = {1'b0, col_reg} + (COL_W + 1)'(4);
        tab_col   = {tab_sum[COL_W:2], 2'b00};
        last_row  = (row_reg == ROW_W'(tmtw_pkg::ROWS - 1));
        nl_addr   = addr_reg - ADDR_W'(col_reg) + ADDR_W'(tmtw_pkg::COLUMNS);

        priority if (char_code == tmtw_pkg::CH_NEWLINE)
        begin
            advance = 1'b1;
        end
        else if (char_code == tmtw_pkg::CH_BACKSPACE)
        begin
            if (col_reg != '0)
            begin
                col_next      = col_reg - COL_W'(1);
                addr_next     = addr_reg - ADDR_W'(1);
                plan.wr_en    = 1'b1;
                plan.wr_addr  = addr_reg - ADDR_W'(1);
                plan.wr_char  = tmtw_pkg::CH_BLANK;
            end
        end
        else if (char_code == tmtw_pkg::CH_TAB)
        begin
            if (32'(tab_col) >= 32'(tmtw_pkg::COLUMNS))
            begin
                advance = 1'b1;
            end
            else
            begin
                col_next  = tab_col[COL_W-1:0];
                addr_next = addr_reg + ADDR_W'(tab_col) - ADDR_W'(col_reg);
            end
        end
        else
        begin
            plan.wr_en   = 1'b1;
            plan.wr_addr = addr_reg;
            plan.wr_char = char_code;
            if (col_reg == COL_W'(tmtw_pkg::COLUMNS - 1))
            begin
                advance = 1'b1;
            end
            else
            begin
                col_next  = col_reg + COL_W'(1);
                addr_next = addr_reg + ADDR_W'(1);
            end
        end

        if (advance)
        begin
            col_next = '0;
            if (last_row)
            begin
                plan.scroll = 1'b1;
                addr_next   = ADDR_W'(tmtw_pkg::LAST_ROW_BASE);
            end
            else
            begin
                row_next  = row_reg + ROW_W'(1);
                addr_next = nl_addr;
            end
        end

        if (home)
        begin
            row_next  = '0;
            col_next  = '0;
            addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            col_reg  <= '0;
            addr_reg <= '0;
        end
        else if (step || home)
        begin
            row_reg  <= row_next;
            col_reg  <= col_next;
            addr_reg <= addr_next;
        end
    end

    assign cursor_addr = addr_reg;

endmodule
